// ----- hdl/dpw_pkg.sv -----
// types and constants shared by the depth pixel to world point block
// no dependencies
package dpw_pkg;

	localparam int MAX_ROWS    = 1024;
	localparam int MAX_COLS    = 1024;
	localparam int DIM_W       = 13;
	localparam int ROW_W       = 10;
	localparam int COL_W       = 10;
	localparam int DEPTH_W     = 16;
	localparam int COLOR_W     = 8;
	localparam int POINT_W     = 24;
	localparam int HALF_W      = 16;
	localparam int OFS_W       = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;

	localparam logic [DEPTH_W-1:0] DEPTH_MIN_RST = 16'd100;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX_RST = 16'd3000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRINCIPAL_POINT = 3'd0,
		REG_INVERSE_FOCAL   = 3'd1,
		REG_DEPTH_MIN       = 3'd2,
		REG_DEPTH_MAX       = 3'd3,
		REG_ROW_X           = 3'd4,
		REG_ROW_Y           = 3'd5,
		REG_ROW_Z           = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic signed [HALF_W-1:0] t;
		logic signed [HALF_W-1:0] c2;
		logic signed [HALF_W-1:0] c1;
		logic signed [HALF_W-1:0] c0;
	} xform_row_t;

	typedef struct packed {
		logic [HALF_W-1:0]  cx;
		logic [HALF_W-1:0]  cy;
		logic [HALF_W-1:0]  ifx;
		logic [HALF_W-1:0]  ify;
		logic [DEPTH_W-1:0] depth_min;
		logic [DEPTH_W-1:0] depth_max;
		xform_row_t         row_x;
		xform_row_t         row_y;
		xform_row_t         row_z;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] dx;
		logic signed [OFS_W-1:0] dy;
		logic [DEPTH_W-1:0]      depth;
		color_t                  color;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- hdl/dpw_pixel_if.sv -----
// request channel carrying one depth pixel with its position and color
// depends on dpw_pkg
interface dpw_pixel_if import dpw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   pixel_row;
	logic [COL_W-1:0]   pixel_col;
	logic [DEPTH_W-1:0] depth_mm;
	logic               depth_valid;
	logic [COLOR_W-1:0] red_in;
	logic [COLOR_W-1:0] green_in;
	logic [COLOR_W-1:0] blue_in;

	modport source (output valid, pixel_row, pixel_col, depth_mm, depth_valid,
		red_in, green_in, blue_in, input ready);
	modport sink (input valid, pixel_row, pixel_col, depth_mm, depth_valid,
		red_in, green_in, blue_in, output ready);
endinterface

// ----- hdl/dpw_point_if.sv -----
// request channel carrying one colored world point
// depends on dpw_pkg
interface dpw_point_if import dpw_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;
	logic signed [POINT_W-1:0] point_z;
	logic [COLOR_W-1:0]        red_out;
	logic [COLOR_W-1:0]        green_out;
	logic [COLOR_W-1:0]        blue_out;

	modport source (output valid, point_x, point_y, point_z, red_out, green_out,
		blue_out, input ready);
	modport sink (input valid, point_x, point_y, point_z, red_out, green_out,
		blue_out, output ready);
endinterface

// ----- hdl/depth_pixel_to_world_point.sv -----
// depth pixel to world point, top level
// an accepted pixel reaches its point through the queue write and six back end stages
// throughput: one pixel per cycle while the point channel is ready, set by the fully pipelined back end multipliers
// dropped pixels leave the front end at once and produce no point
// reset: queue and pipeline empty, depth bounds 100 and 3000 mm, other configuration registers zero
module depth_pixel_to_world_point import dpw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dpw_pixel_if.sink             pixel,
	dpw_point_if.source           point
);

	cfg_t       cfg;
	fifo_stat_t stat;
	logic       push;
	logic       pop;
	work_t      push_data;
	work_t      head;

	dpw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dpw_front u_front (
		.cfg       (cfg),
		.pixel     (pixel),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	dpw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	dpw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.stat   (stat),
		.head   (head),
		.pop    (pop),
		.point  (point)
	);

endmodule

// ----- hdl/dpw_cfg.sv -----
// configuration register file, written through a plain write port
// depends on dpw_pkg
module dpw_cfg import dpw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cx        <= '0;
			cfg_q.cy        <= '0;
			cfg_q.ifx       <= '0;
			cfg_q.ify       <= '0;
			cfg_q.depth_min <= DEPTH_MIN_RST;
			cfg_q.depth_max <= DEPTH_MAX_RST;
			cfg_q.row_x     <= '0;
			cfg_q.row_y     <= '0;
			cfg_q.row_z     <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PRINCIPAL_POINT: begin
					cfg_q.cx <= cfg_data[15:0];
					cfg_q.cy <= cfg_data[31:16];
				end
				REG_INVERSE_FOCAL: begin
					cfg_q.ifx <= cfg_data[15:0];
					cfg_q.ify <= cfg_data[31:16];
				end
				REG_DEPTH_MIN: cfg_q.depth_min <= cfg_data[DEPTH_W-1:0];
				REG_DEPTH_MAX: cfg_q.depth_max <= cfg_data[DEPTH_W-1:0];
				REG_ROW_X:     cfg_q.row_x <= xform_row_t'(cfg_data);
				REG_ROW_Y:     cfg_q.row_y <= xform_row_t'(cfg_data);
				REG_ROW_Z:     cfg_q.row_z <= xform_row_t'(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/dpw_front.sv -----
// front end: accepts pixels, drops invalid and out of range ones, forms principal point offsets
// depends on dpw_pkg and dpw_pixel_if
module dpw_front import dpw_pkg::*; (
	input  cfg_t         cfg,
	dpw_pixel_if.sink    pixel,
	input  fifo_stat_t   stat,
	output logic         push,
	output work_t        push_data
);

	logic keep;

	assign pixel.ready = !stat.full;

	always_comb begin
		keep = pixel.depth_valid
			&& (pixel.depth_mm >= cfg.depth_min)
			&& (pixel.depth_mm <= cfg.depth_max)
			&& (DIM_W'(pixel.pixel_row) < DIM_W'(MAX_ROWS))
			&& (DIM_W'(pixel.pixel_col) < DIM_W'(MAX_COLS));
	end

	assign push = pixel.valid && pixel.ready && keep;

	always_comb begin
		push_data.dx = $signed({4'b0, pixel.pixel_col, 4'b0}) - $signed({2'b0, cfg.cx});
		push_data.dy = $signed({4'b0, pixel.pixel_row, 4'b0}) - $signed({2'b0, cfg.cy});
		push_data.depth       = pixel.depth_mm;
		push_data.color.red   = pixel.red_in;
		push_data.color.green = pixel.green_in;
		push_data.color.blue  = pixel.blue_in;
	end

endmodule

// ----- hdl/dpw_fifo.sv -----
// short queue between front end and back end
// depends on dpw_pkg
module dpw_fifo import dpw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  work_t      push_data,
	input  logic       pop,
	output work_t      head,
	output fifo_stat_t stat
);

	work_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW:0]   wr_q;
	logic [FIFO_AW:0]   rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[FIFO_AW-1:0]] <= push_data;
	end

	assign head       = mem_q[rd_q[FIFO_AW-1:0]];
	assign stat.empty = (wr_q == rd_q);
	assign stat.full  = (wr_q[FIFO_AW] != rd_q[FIFO_AW])
		&& (wr_q[FIFO_AW-1:0] == rd_q[FIFO_AW-1:0]);

endmodule

// ----- hdl/dpw_back.sv -----
// back end: pinhole back-projection, rigid transform, rounding and saturation
// depends on dpw_pkg and dpw_point_if
module dpw_back import dpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  fifo_stat_t  stat,
	input  work_t       head,
	output logic        pop,
	dpw_point_if.source point
);

	localparam int PZ_W  = OFS_W + DEPTH_W + 1;
	localparam int PF_W  = PZ_W + HALF_W + 1;
	localparam int CAM_W = PF_W - 24;
	localparam int ZC_W  = DEPTH_W + 4;
	localparam int P01_W = HALF_W + CAM_W;
	localparam int P2_W  = HALF_W + ZC_W + 1;
	localparam int ACC_W = 48;
	localparam int RES_W = ACC_W - 17;

	localparam logic signed [PF_W-1:0]  RND24 = PF_W'(1) <<< 23;
	localparam logic signed [ACC_W-1:0] RND17 = ACC_W'(1) <<< 16;
	localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(8388607);
	localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(8388608);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [PZ_W-1:0]  px_s1, py_s1;
	logic [ZC_W-1:0]         zc_s1, zc_s2, zc_s3;
	logic signed [PF_W-1:0]  qx_s2, qy_s2;
	logic signed [PF_W-1:0]  rx, ry;
	logic signed [CAM_W-1:0] xc_s3, yc_s3;
	logic signed [P01_W-1:0] p0_s4 [3];
	logic signed [P01_W-1:0] p1_s4 [3];
	logic signed [P2_W-1:0]  p2_s4 [3];
	logic signed [ACC_W-1:0] acc   [3];
	logic signed [ACC_W-1:0] acc_s5 [3];
	logic signed [RES_W-1:0] res   [3];
	logic signed [POINT_W-1:0] pt_s6 [3];
	color_t                  col_s1, col_s2, col_s3, col_s4, col_s5, col_s6;
	xform_row_t              rows  [3];

	assign en  = !v_s6 || point.ready;
	assign pop = !stat.empty && en;

	always_comb begin
		rows[0] = cfg.row_x;
		rows[1] = cfg.row_y;
		rows[2] = cfg.row_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		rx = qx_s2 + RND24;
		ry = qy_s2 + RND24;
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(p0_s4[i]) + ACC_W'(p1_s4[i]) + ACC_W'(p2_s4[i])
				+ (ACC_W'(rows[i].t) <<< 17) + RND17;
			res[i] = $signed(acc_s5[i][ACC_W-1:17]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= head.dx * $signed({1'b0, head.depth});
			py_s1  <= head.dy * $signed({1'b0, head.depth});
			zc_s1  <= {head.depth, 4'b0};
			col_s1 <= head.color;

			qx_s2  <= px_s1 * $signed({1'b0, cfg.ifx});
			qy_s2  <= py_s1 * $signed({1'b0, cfg.ify});
			zc_s2  <= zc_s1;
			col_s2 <= col_s1;

			xc_s3  <= rx[PF_W-1:24];
			yc_s3  <= ry[PF_W-1:24];
			zc_s3  <= zc_s2;
			col_s3 <= col_s2;

			for (int i = 0; i < 3; i++) begin
				p0_s4[i] <= rows[i].c0 * xc_s3;
				p1_s4[i] <= rows[i].c1 * yc_s3;
				p2_s4[i] <= rows[i].c2 * $signed({1'b0, zc_s3});
				acc_s5[i] <= acc[i];
				if (res[i] > SAT_HI) begin
					pt_s6[i] <= SAT_HI[POINT_W-1:0];
				end else if (res[i] < SAT_LO) begin
					pt_s6[i] <= SAT_LO[POINT_W-1:0];
				end else begin
					pt_s6[i] <= res[i][POINT_W-1:0];
				end
			end
			col_s4 <= col_s3;
			col_s5 <= col_s4;
			col_s6 <= col_s5;
		end
	end

	assign point.valid     = v_s6;
	assign point.point_x   = pt_s6[0];
	assign point.point_y   = pt_s6[1];
	assign point.point_z   = pt_s6[2];
	assign point.red_out   = col_s6.red;
	assign point.green_out = col_s6.green;
	assign point.blue_out  = col_s6.blue;

endmodule
